// ----- hdl/tis_pkg.sv -----
// ----------------------------------------------------------------------------
// tis_pkg
// Shared constants and types for the timestamp interpolating sync block.
// ----------------------------------------------------------------------------
package tis_pkg;

    localparam int DEPTH       = 16;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int VALUE_WIDTH = 32;
    localparam int STAMP_WIDTH = 48;
    localparam int GAP_WIDTH   = 24;
    localparam int NCOMP       = 6;
    localparam int RATIO_W     = 17;

    localparam logic [GAP_WIDTH-1:0] GAP_RESET = 24'd200000;

    localparam logic [1:0] ST_SYNCED = 2'd0;
    localparam logic [1:0] ST_NEWER  = 2'd1;
    localparam logic [1:0] ST_FEW    = 2'd2;
    localparam logic [1:0] ST_GAP    = 2'd3;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_SYNC = 1'b1;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef value_t [NCOMP-1:0] vec_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic push;      // write captured sample
        logic rd;        // read front pair
        logic pop;       // drop front
        logic div_start; // start ratio divider
        logic blend;     // start blend
        logic result;    // load output register
        logic [1:0] status;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_push;
        logic few;        // fewer than two samples
        logic front_newer;
        logic second_old;
        logic gap_bad;
        logic div_done;
        logic blend_done;
        logic out_busy;
    } sts_t;

endpackage

// ----- hdl/tis_datapath.sv -----
// ----------------------------------------------------------------------------
// tis_datapath
// Sample FIFO, ratio divider, serial blend and output register.
// ----------------------------------------------------------------------------
module tis_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tis_pkg::cmd_t                   cmd,
    output tis_pkg::sts_t                   sts,
    input  logic [tis_pkg::GAP_WIDTH-1:0]   max_gap,
    input  logic                            s_opcode,
    input  logic [tis_pkg::STAMP_WIDTH-1:0] s_stamp,
    input  tis_pkg::vec_t                   s_vec,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [tis_pkg::STAMP_WIDTH-1:0] m_out_stamp,
    output tis_pkg::vec_t                   m_vec
);
    localparam int SW = tis_pkg::STAMP_WIDTH;
    localparam int VW = tis_pkg::VALUE_WIDTH;
    localparam int IW = tis_pkg::IDX_W;
    localparam int CW = tis_pkg::CNT_W;
    localparam int RW = tis_pkg::RATIO_W;
    localparam int NUM_W = tis_pkg::GAP_WIDTH + 16;
    localparam int DIV_STEPS = RW;
    localparam int DC_W = $clog2(DIV_STEPS + 1);
    localparam int CI_W = $clog2(tis_pkg::NCOMP);

    // captured input
    logic                  op_reg;
    logic [SW-1:0]         t_reg;
    tis_pkg::vec_t         in_vec_reg;

    // FIFO storage and pointers
    logic [SW-1:0]         stamp_mem [tis_pkg::DEPTH];
    tis_pkg::vec_t         val_mem   [tis_pkg::DEPTH];
    logic [IW-1:0]         head_reg, head_next;
    logic [CW-1:0]         fill_reg, fill_next;

    logic [SW-1:0]         f_reg, s_reg;
    tis_pkg::vec_t         a_reg, b_reg;
    logic [IW-1:0]         h1;
    logic [IW-1:0]         wr_idx;

    assign h1     = head_reg + IW'(1);
    assign wr_idx = head_reg + fill_reg[IW-1:0];

    // memory write and front pair read
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            stamp_mem[cmd.pop ? head_reg : wr_idx] <= t_reg;
            val_mem[cmd.pop ? head_reg : wr_idx]   <= in_vec_reg;
        end
        if (cmd.rd) begin
            f_reg <= stamp_mem[head_reg];
            s_reg <= stamp_mem[h1];
            a_reg <= val_mem[head_reg];
            b_reg <= val_mem[h1];
        end
        if (cmd.load) begin
            op_reg     <= s_opcode;
            t_reg      <= s_stamp;
            in_vec_reg <= s_vec;
        end
    end

    // pointer update; a full push overwrites the oldest slot
    always_comb begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (cmd.push) begin
            if (fill_reg == CW'(tis_pkg::DEPTH)) begin
                head_next = h1;
            end else begin
                fill_next = fill_reg + CW'(1);
            end
        end else if (cmd.pop && fill_reg != '0) begin
            head_next = h1;
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    // comparisons on the registered front pair
    logic [SW-1:0] tf, st;
    assign tf = t_reg - f_reg;
    assign st = s_reg - t_reg;

    assign sts.is_push     = (op_reg == tis_pkg::OP_PUSH);
    assign sts.few         = (fill_reg < CW'(2));
    assign sts.front_newer = (f_reg > t_reg);
    assign sts.second_old  = (s_reg < t_reg);
    assign sts.gap_bad     = (tf > SW'(max_gap)) || (st > SW'(max_gap));

    // restoring divider: r = (tf << 16) / span, one quotient bit a cycle
    logic [SW-1:0]    span_reg;
    logic [NUM_W-1:0] num_reg;
    logic [SW:0]      rem_reg;
    logic [RW-1:0]    q_reg;
    logic [DC_W-1:0]  dcnt_reg;
    logic             div_busy_reg;
    logic             zspan_reg;
    logic [SW:0]      rem_sh;

    assign rem_sh = {rem_reg[SW-1:0], num_reg[NUM_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
        end else if (cmd.div_start) begin
            div_busy_reg <= (s_reg != f_reg);
        end else if (div_busy_reg && dcnt_reg == DC_W'(1)) begin
            div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            span_reg  <= s_reg - f_reg;
            zspan_reg <= (s_reg == f_reg);
            // tf <= max_gap here, fits in GAP_WIDTH bits
            num_reg   <= {tf[tis_pkg::GAP_WIDTH-1:0], 16'd0} << (NUM_W - 16
                         - tis_pkg::GAP_WIDTH + (tis_pkg::GAP_WIDTH + 16 - RW));
            rem_reg   <= (SW+1)'({tf[tis_pkg::GAP_WIDTH-1:0], 16'd0} >> RW);
            q_reg     <= '0;
            dcnt_reg  <= DC_W'(DIV_STEPS);
        end else if (div_busy_reg) begin
            num_reg  <= num_reg << 1;
            dcnt_reg <= dcnt_reg - DC_W'(1);
            if (rem_sh >= {1'b0, span_reg}) begin
                rem_reg <= rem_sh - {1'b0, span_reg};
                q_reg   <= {q_reg[RW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[RW-2:0], 1'b0};
            end
        end
    end

    logic div_start_d;
    always_ff @(posedge aclk) begin
        if (!aresetn) div_start_d <= 1'b0;
        else          div_start_d <= cmd.div_start;
    end
    assign sts.div_done = !div_busy_reg && !div_start_d;

    // serial blend: out = a + floor((b - a) * r / 65536), one component a cycle
    logic [CI_W-1:0]          ci_reg;
    logic                     bl_busy_reg;
    logic                     bl_done_reg;
    logic [RW-1:0]            r_use;
    logic signed [VW:0]       d;
    logic signed [VW+RW+1:0]  prod;
    tis_pkg::vec_t            res_reg;

    assign r_use = zspan_reg ? '0 : ((q_reg > RW'(65536)) ? RW'(65536) : q_reg);
    assign d     = {b_reg[ci_reg][VW-1], b_reg[ci_reg]} - {a_reg[ci_reg][VW-1], a_reg[ci_reg]};
    assign prod  = d * $signed({1'b0, r_use});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bl_busy_reg <= 1'b0;
            bl_done_reg <= 1'b0;
            ci_reg      <= '0;
        end else if (cmd.blend) begin
            bl_busy_reg <= 1'b1;
            bl_done_reg <= 1'b0;
            ci_reg      <= '0;
        end else if (bl_busy_reg) begin
            if (ci_reg == CI_W'(tis_pkg::NCOMP - 1)) begin
                bl_busy_reg <= 1'b0;
                bl_done_reg <= 1'b1;
            end else begin
                ci_reg <= ci_reg + CI_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (bl_busy_reg) begin
            res_reg[ci_reg] <= a_reg[ci_reg] + VW'(prod >>> 16);
        end
    end
    assign sts.blend_done = bl_done_reg && !cmd.blend;

    // output register
    logic m_valid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result) begin
            m_status    <= cmd.status;
            m_out_stamp <= t_reg;
            m_vec       <= (cmd.status == tis_pkg::ST_SYNCED) ? res_reg : '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign sts.out_busy = m_valid_reg && !m_ready;

endmodule

// ----- hdl/tis_ctrl.sv -----
// ----------------------------------------------------------------------------
// tis_ctrl
// Sequencer for push, front discard, checks, divide and blend.
// ----------------------------------------------------------------------------
module tis_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output tis_pkg::cmd_t  cmd,
    input  tis_pkg::sts_t  sts
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_DIVW  = 4'd5;
    localparam logic [3:0] S_BLEND = 4'd6;
    localparam logic [3:0] S_BLW   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_WAIT  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [1:0] stat_reg, stat_next;

    always_comb begin
        state_next = state_reg;
        stat_next  = stat_reg;
        cmd        = '0;
        cmd.status = stat_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) state_next = S_DEC;
            end
            S_DEC: begin
                if (sts.is_push) begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (sts.few) begin
                    stat_next  = tis_pkg::ST_FEW;
                    state_next = S_OUT;
                end else if (sts.front_newer) begin
                    stat_next  = tis_pkg::ST_NEWER;
                    state_next = S_OUT;
                end else if (sts.second_old) begin
                    cmd.pop    = 1'b1;
                    state_next = S_READ;
                end else if (sts.gap_bad) begin
                    cmd.pop    = 1'b1;
                    stat_next  = tis_pkg::ST_GAP;
                    state_next = S_OUT;
                end else begin
                    stat_next  = tis_pkg::ST_SYNCED;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW: begin
                if (sts.div_done) state_next = S_BLEND;
            end
            S_BLEND: begin
                cmd.blend  = 1'b1;
                state_next = S_BLW;
            end
            S_BLW: begin
                if (sts.blend_done) state_next = S_OUT;
            end
            S_OUT: begin
                if (!sts.out_busy) begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WAIT: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            stat_reg  <= tis_pkg::ST_SYNCED;
        end else begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
        end
    end

endmodule

// ----- hdl/timestamp_interpolating_sync.sv -----
// Sequence: a push passes the load and decode states; a request adds a read and check
//   per discarded front sample, plus divide and six-component blend when synced.
// Throughput: one item at a time, set by the serial divider and blend multiplier.
// The output register lets a new item start while a result waits.
// Reset (aresetn low, synchronous) empties the FIFO and sets max_gap to 200000.
// ----------------------------------------------------------------------------
// timestamp_interpolating_sync
// Velocity sample FIFO with time-interpolating sync requests.
// ----------------------------------------------------------------------------
module timestamp_interpolating_sync (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [47:0] s_stamp,
    input  logic signed [31:0] s_lin_x,
    input  logic signed [31:0] s_lin_y,
    input  logic signed [31:0] s_lin_z,
    input  logic signed [31:0] s_ang_x,
    input  logic signed [31:0] s_ang_y,
    input  logic signed [31:0] s_ang_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [47:0] m_out_stamp,
    output logic signed [31:0] m_out_lin_x,
    output logic signed [31:0] m_out_lin_y,
    output logic signed [31:0] m_out_lin_z,
    output logic signed [31:0] m_out_ang_x,
    output logic signed [31:0] m_out_ang_y,
    output logic signed [31:0] m_out_ang_z
);
    tis_pkg::cmd_t cmd;
    tis_pkg::sts_t sts;
    tis_pkg::vec_t in_vec, out_vec;
    logic [tis_pkg::GAP_WIDTH-1:0] gap_reg;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg <= tis_pkg::GAP_RESET;
        end else if (cfg_valid) begin
            gap_reg <= cfg_data;
        end
    end

    assign in_vec = {s_ang_z, s_ang_y, s_ang_x, s_lin_z, s_lin_y, s_lin_x};
    assign {m_out_ang_z, m_out_ang_y, m_out_ang_x,
            m_out_lin_z, m_out_lin_y, m_out_lin_x} = out_vec;

    tis_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    tis_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .max_gap     (gap_reg),
        .s_opcode    (s_opcode),
        .s_stamp     (s_stamp),
        .s_vec       (in_vec),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_out_stamp (m_out_stamp),
        .m_vec       (out_vec)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives pushes and sync requests through the velocity sample FIFO, predicts
// each sync result with an in-bench interpolation model, and checks every
// result field against it under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int QUEUE_DEPTH  = 4096;

    typedef struct {
        logic                            op;
        logic [tis_pkg::STAMP_WIDTH-1:0] stamp;
        tis_pkg::vec_t                   val;
    } req_t;

    typedef struct {
        logic [1:0]                      status;
        logic [tis_pkg::STAMP_WIDTH-1:0] stamp;
        tis_pkg::vec_t                   val;
    } sync_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [23:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_opcode = 1'b0;
    logic [47:0] s_stamp = '0;
    tis_pkg::vec_t s_val = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_status;
    logic [47:0] m_out_stamp;
    tis_pkg::vec_t m_val;

    // stimulus and expected results, kept as arrays with running indexes
    req_t  pend_q[QUEUE_DEPTH];
    int    pend_wr = 0;
    int    pend_rd = 0;
    sync_t exp_q[QUEUE_DEPTH];
    int    exp_wr = 0;
    int    exp_rd = 0;
    int    mismatches = 0;
    int    cycles = 0;
    bit    hold_sender = 1'b0;
    bit    cfg_busy = 1'b0;

    // predictor state
    logic [tis_pkg::GAP_WIDTH-1:0]   pred_gap;
    logic [tis_pkg::STAMP_WIDTH-1:0] pred_stamps[tis_pkg::DEPTH];
    tis_pkg::vec_t                   pred_vals[tis_pkg::DEPTH];
    int                              pred_head;
    int                              pred_fill;

    // running stamp for well-formed streams
    logic [tis_pkg::STAMP_WIDTH-1:0] clock_us;

    timestamp_interpolating_sync dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode), .s_stamp(s_stamp),
        .s_lin_x(s_val[0]), .s_lin_y(s_val[1]), .s_lin_z(s_val[2]),
        .s_ang_x(s_val[3]), .s_ang_y(s_val[4]), .s_ang_z(s_val[5]),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_out_stamp(m_out_stamp),
        .m_out_lin_x(m_val[0]), .m_out_lin_y(m_val[1]), .m_out_lin_z(m_val[2]),
        .m_out_ang_x(m_val[3]), .m_out_ang_y(m_val[4]), .m_out_ang_z(m_val[5])
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic void pred_pop();
        if (pred_fill > 0) begin
            pred_head = (pred_head + 1) % tis_pkg::DEPTH;
            pred_fill--;
        end
    endfunction

    // a + floor((b - a) * r / 65536), exact
    function automatic tis_pkg::value_t lerp_value(tis_pkg::value_t a, tis_pkg::value_t b,
                                                   logic [16:0] r);
        logic signed [63:0] d;
        logic signed [63:0] p;
        d = 64'(signed'(b)) - 64'(signed'(a));
        p = d * $signed({47'd0, r});
        return tis_pkg::value_t'(64'(signed'(a)) + (p >>> 16));
    endfunction

    // apply one accepted request to the predictor
    function automatic void predict_request(req_t rq);
        sync_t res;
        logic [tis_pkg::STAMP_WIDTH-1:0] f, s, span;
        logic [63:0] ratio;
        int p0, p1;
        if (rq.op == tis_pkg::OP_PUSH) begin
            if (pred_fill >= tis_pkg::DEPTH) pred_pop();
            p0 = (pred_head + pred_fill) % tis_pkg::DEPTH;
            pred_stamps[p0] = rq.stamp;
            pred_vals[p0] = rq.val;
            pred_fill++;
            return;
        end
        res.status = tis_pkg::ST_SYNCED;
        res.stamp = rq.stamp;
        res.val = '0;
        while (pred_fill >= 2) begin
            f = pred_stamps[pred_head];
            s = pred_stamps[(pred_head + 1) % tis_pkg::DEPTH];
            if (f > rq.stamp) begin
                res.status = tis_pkg::ST_NEWER;
                break;
            end
            if (s < rq.stamp) begin
                pred_pop();
                continue;
            end
            if (rq.stamp - f > pred_gap || s - rq.stamp > pred_gap) begin
                pred_pop();
                res.status = tis_pkg::ST_GAP;
            end
            break;
        end
        if (res.status == tis_pkg::ST_SYNCED && pred_fill < 2) res.status = tis_pkg::ST_FEW;
        if (res.status == tis_pkg::ST_SYNCED) begin
            p0 = pred_head;
            p1 = (pred_head + 1) % tis_pkg::DEPTH;
            span = pred_stamps[p1] - pred_stamps[p0];
            if (span == 0) begin
                res.val = pred_vals[p0];
            end else begin
                ratio = ({16'd0, rq.stamp - pred_stamps[p0]} << 16) / {16'd0, span};
                if (ratio > 64'd65536) ratio = 64'd65536;
                for (int i = 0; i < tis_pkg::NCOMP; i++)
                    res.val[i] = lerp_value(pred_vals[p0][i], pred_vals[p1][i], ratio[16:0]);
            end
        end
        exp_q[exp_wr] = res;
        exp_wr++;
    endfunction

    function automatic int idle_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic tis_pkg::vec_t rand_vec();
        tis_pkg::vec_t v;
        int k;
        for (int i = 0; i < tis_pkg::NCOMP; i++) begin
            k = $urandom_range(0, 9);
            if (k == 0) v[i] = 32'sh7fffffff;
            else if (k == 1) v[i] = 32'sh80000000;
            else v[i] = $urandom;
        end
        return v;
    endfunction

    function automatic void add_req(logic op, logic [tis_pkg::STAMP_WIDTH-1:0] st,
                                    tis_pkg::vec_t v);
        req_t rq;
        rq.op = op;
        rq.stamp = st;
        rq.val = v;
        pend_q[pend_wr] = rq;
        pend_wr++;
    endfunction

    // driver: request channel
    int s_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_request(pend_q[pend_rd]);
                pend_rd++;
                s_gap <= idle_len();
                s_valid <= 1'b0;
            end else if (!s_valid) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                end else if (pend_wr > pend_rd && !hold_sender && !cfg_busy) begin
                    s_valid <= 1'b1;
                    s_opcode <= pend_q[pend_rd].op;
                    s_stamp <= pend_q[pend_rd].stamp;
                    s_val <= pend_q[pend_rd].val;
                end
            end
        end
    end

    // monitor: result channel with random stall
    int m_stall = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (exp_wr == exp_rd) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result status=%0d stamp=%0d", m_status, m_out_stamp);
                end else begin
                    sync_t e;
                    e = exp_q[exp_rd];
                    exp_rd++;
                    if (e.status !== m_status || e.stamp !== m_out_stamp || e.val !== m_val) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp st=%0d t=%0d v=%h act st=%0d t=%0d v=%h",
                                     e.status, e.stamp, e.val, m_status, m_out_stamp, m_val);
                    end
                end
            end
            if (m_stall > 0) begin
                m_stall <= m_stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (m_valid && m_ready) m_stall <= idle_len();
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (cycles >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pend_wr > pend_rd || s_valid || exp_wr > exp_rd)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_gap(logic [23:0] g);
        wait_drained();
        cfg_busy = 1'b1;
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= g;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        pred_gap = g;
        cfg_busy = 1'b0;
    endtask

    // a mostly well-formed burst: pushes mixed with requests, plus some random and far-future items
    task automatic add_stream(int n);
        logic [tis_pkg::STAMP_WIDTH-1:0] st;
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 50) begin
                clock_us = clock_us + $urandom_range(0, 3) * $urandom_range(0, 30000);
                add_req(tis_pkg::OP_PUSH, clock_us, rand_vec());
            end else if (k < 92) begin
                st = clock_us - $urandom_range(0, 90000);
                add_req(tis_pkg::OP_SYNC, st, rand_vec());
            end else if (k < 97) begin
                add_req(k[0], 48'({$urandom, $urandom}), rand_vec());
            end else begin
                add_req(tis_pkg::OP_SYNC, clock_us + $urandom_range(0, 400000), rand_vec());
            end
        end
    endtask

    initial begin
        tis_pkg::vec_t lo, hi;
        pred_gap = tis_pkg::GAP_RESET;
        pred_head = 0;
        pred_fill = 0;
        clock_us = 48'd1000000;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: few samples, newer front, zero span, extremes, gap, overflow
        lo = {tis_pkg::NCOMP{32'sh80000000}};
        hi = {tis_pkg::NCOMP{32'sh7fffffff}};
        add_req(tis_pkg::OP_SYNC, 48'd0, '0);
        add_req(tis_pkg::OP_PUSH, 48'd100, lo);
        add_req(tis_pkg::OP_SYNC, 48'd50, '0);
        add_req(tis_pkg::OP_PUSH, 48'd100, hi);
        add_req(tis_pkg::OP_SYNC, 48'd100, '0);
        add_req(tis_pkg::OP_PUSH, 48'd1100, hi);
        add_req(tis_pkg::OP_SYNC, 48'd10, '0);
        add_req(tis_pkg::OP_SYNC, 48'd400, '0);
        add_req(tis_pkg::OP_SYNC, 48'd1099, '0);
        add_req(tis_pkg::OP_PUSH, 48'd900000, lo);
        add_req(tis_pkg::OP_SYNC, 48'd500000, '0);
        add_req(tis_pkg::OP_SYNC, 48'd900000, '0);
        for (int i = 0; i < 18; i++)
            add_req(tis_pkg::OP_PUSH, 48'd1000000 + 48'(i * 1000), rand_vec());
        add_req(tis_pkg::OP_SYNC, 48'hffffffffffff, hi);
        add_req(tis_pkg::OP_PUSH, 48'hffffffffffff, hi);
        add_req(tis_pkg::OP_SYNC, 48'hffffffffffff, '0);

        // pause the sender mid-list until every result is back
        wait (pend_wr - pend_rd <= 24);
        hold_sender = 1'b1;
        wait (!s_valid && exp_wr == exp_rd);
        hold_sender = 1'b0;

        // drain the FIFO before random phases via a far-future request
        write_gap(24'd0);
        clock_us = 48'd5000000;
        add_req(tis_pkg::OP_SYNC, 48'hfffffffffffe, '0);
        add_stream(300);
        write_gap(24'hffffff);
        add_req(tis_pkg::OP_SYNC, 48'hfffffffffffe, '0);
        clock_us = 48'd9000000;
        add_stream(500);
        write_gap(24'd1);
        add_req(tis_pkg::OP_SYNC, 48'hfffffffffffe, '0);
        add_stream(200);
        write_gap(24'd40000);
        add_stream(500);
        write_gap(24'd200000);
        add_stream(300);

        wait_drained();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
